/* rtl/core/ibdsg_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// ibdsg_pkg
// shared constants for the ibd segment generator: action and kind codes,
// register map, parameter defaults and bus widths
// ---------------------------------------------------------------------------
package ibdsg_pkg;

  // parameter defaults
  localparam int FREE_BITS_MAX_DEF = 8;
  localparam int FIXED_MAX_DEF     = 8;
  localparam int POSITION_BITS_DEF = 32;

  // input actions
  localparam logic [2:0] ACT_LOAD_STATE = 3'd0;
  localparam logic [2:0] ACT_LOAD_MASK  = 3'd1;
  localparam logic [2:0] ACT_START      = 3'd2;
  localparam logic [2:0] ACT_STEP       = 3'd3;
  localparam logic [2:0] ACT_FINISH     = 3'd4;

  // result kinds
  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_STATS   = 1'b1;

  // register indexes (byte address 4*index)
  localparam logic [1:0] REG_TOTAL  = 2'd0;
  localparam logic [1:0] REG_FIXED  = 2'd1;
  localparam logic [1:0] REG_MERGE  = 2'd2;
  localparam logic [1:0] REG_STATS  = 2'd3;

  // register reset values
  localparam logic [4:0] TOTAL_RST = 5'd2;
  localparam logic [3:0] FIXED_RST = 4'd0;
  localparam logic       MERGE_RST = 1'b1;
  localparam logic [1:0] STATS_RST = 2'd1;

  // bus widths
  localparam int IN_TDATA_W  = 96;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 184;
  localparam int OUT_TUSER_W = 1;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  // statistics field widths
  localparam int SUM_W   = 40;
  localparam int TALLY_W = 16;
  localparam int SAMPLE_W = 16;
  localparam int CHROM_W  = 8;

endpackage

`default_nettype wire

/* rtl/core/ibd_segment_generator_unit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// ibd_segment_generator_unit
// walks an inheritance vector along a chromosome and emits ibd segments
// ---------------------------------------------------------------------------
// usage:
//   in_*   stream of beats; in_tuser carries the action (load state entry,
//          load mask, start chromosome, step, finish sample), in_tdata the
//          operands. load and start beats give no result, a step gives at
//          most one segment record, a finish always gives a statistics record
//   out_*  stream of result beats; out_tuser is the record kind
//   cfg_*  apb-style register port, pready tied high, to be written only while idle (not enforced)
// timing:
//   one beat per cycle sustained while the output is not stalled. the accept
//   edge issues the state table read; the lookup stage then compares the
//   looked-up state and loads the output register, unless stalled. the state
//   table is a single-port synchronous ram; the state of the current vector
//   is cached in a register so each step needs only one table read
// reset:
//   synchronous, active low. no chromosome open, sample number one, tallies
//   clear, registers at their defaults. state table and masks are not
//   cleared and must be loaded before use
// stall:
//   the output register plus the lookup stage hold two results; when the
//   output is stalled and the lookup stage has a result, in_tready drops
// ---------------------------------------------------------------------------
module ibd_segment_generator_unit #(
  parameter int FREE_BITS_MAX = ibdsg_pkg::FREE_BITS_MAX_DEF,
  parameter int FIXED_MAX     = ibdsg_pkg::FIXED_MAX_DEF,
  parameter int POSITION_BITS = ibdsg_pkg::POSITION_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // table_index[7:0] table_value[15:8] start_vector[23:16]
  // chrom_length[55:24] draw_length[87:56] draw_transmission[91:88]
  input  wire logic [ibdsg_pkg::IN_TDATA_W-1:0]   in_tdata,
  // action[2:0]
  input  wire logic [ibdsg_pkg::IN_TUSER_W-1:0]   in_tuser,
  // result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // sample_id[15:0] chromosome_id[23:16] seg_start[55:24] seg_end[87:56]
  // seg_length[119:88] ibd_state[121:120] stat_total[161:122]
  // stat_count[177:162]
  output logic [ibdsg_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // kind[0]
  output logic [ibdsg_pkg::OUT_TUSER_W-1:0]       out_tuser,
  // register port
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [ibdsg_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [ibdsg_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [ibdsg_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                    cfg_pready
);

  localparam int VEC_W     = FREE_BITS_MAX;
  localparam int TBL_DEPTH = 1 << VEC_W;
  localparam int MIDX_W    = (FIXED_MAX > 1) ? $clog2(FIXED_MAX) : 1;
  localparam int POS_W     = POSITION_BITS;
  localparam int SUM_W     = ibdsg_pkg::SUM_W;
  localparam int TALLY_W   = ibdsg_pkg::TALLY_W;
  localparam int SAMPLE_W  = ibdsg_pkg::SAMPLE_W;
  localparam int CHROM_W   = ibdsg_pkg::CHROM_W;
  localparam int ACC_W     = ((POS_W > SUM_W) ? POS_W : SUM_W) + 1;

  // -------------------------------------------------------------------------
  // register port
  // -------------------------------------------------------------------------
  logic [4:0] cfg_total_r;
  logic [3:0] cfg_fixed_r;
  logic       cfg_merge_r;
  logic [1:0] cfg_stats_r;
  logic       cfg_we;
  logic [1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_total_r <= ibdsg_pkg::TOTAL_RST;
      cfg_fixed_r <= ibdsg_pkg::FIXED_RST;
      cfg_merge_r <= ibdsg_pkg::MERGE_RST;
      cfg_stats_r <= ibdsg_pkg::STATS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ibdsg_pkg::REG_TOTAL: cfg_total_r <= cfg_pwdata[4:0];
        ibdsg_pkg::REG_FIXED: cfg_fixed_r <= cfg_pwdata[3:0];
        ibdsg_pkg::REG_MERGE: cfg_merge_r <= cfg_pwdata[0];
        ibdsg_pkg::REG_STATS: cfg_stats_r <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      ibdsg_pkg::REG_TOTAL: cfg_prdata[4:0] = cfg_total_r;
      ibdsg_pkg::REG_FIXED: cfg_prdata[3:0] = cfg_fixed_r;
      ibdsg_pkg::REG_MERGE: cfg_prdata[0]   = cfg_merge_r;
      ibdsg_pkg::REG_STATS: cfg_prdata[1:0] = cfg_stats_r;
      default: ;
    endcase
  end

  // -------------------------------------------------------------------------
  // input beat fields
  // -------------------------------------------------------------------------
  logic [2:0]  in_action;
  logic [7:0]  in_table_index;
  logic [7:0]  in_table_value;
  logic [7:0]  in_start_vector;
  logic [31:0] in_chrom_length;
  logic [31:0] in_draw_length;
  logic [3:0]  in_draw_transmission;

  assign in_action            = in_tuser[2:0];
  assign in_table_index       = in_tdata[7:0];
  assign in_table_value       = in_tdata[15:8];
  assign in_start_vector      = in_tdata[23:16];
  assign in_chrom_length      = in_tdata[55:24];
  assign in_draw_length       = in_tdata[87:56];
  assign in_draw_transmission = in_tdata[91:88];

  logic accept;
  assign accept = in_tvalid & in_tready;

  // -------------------------------------------------------------------------
  // front stage state: vector walk, positions, counters
  // -------------------------------------------------------------------------
  logic [VEC_W-1:0]    cur_vec_r;
  logic [POS_W-1:0]    sub_start_r;
  logic [POS_W-1:0]    limit_r;
  logic                active_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [CHROM_W-1:0]  chrom_r;
  logic [VEC_W-1:0]    mask_r [FIXED_MAX];

  logic is_load_state, is_load_mask, is_start, is_step, is_finish;
  assign is_load_state = (in_action == ibdsg_pkg::ACT_LOAD_STATE);
  assign is_load_mask  = (in_action == ibdsg_pkg::ACT_LOAD_MASK);
  assign is_start      = (in_action == ibdsg_pkg::ACT_START);
  assign is_step       = (in_action == ibdsg_pkg::ACT_STEP) & active_r;
  assign is_finish     = (in_action == ibdsg_pkg::ACT_FINISH);

  // transmission split: fixed count clipped to FIXED_MAX and total
  logic [4:0] fix_a, fix_n, free_n, idx5, midx;
  logic [VEC_W-1:0] vec_next;

  always_comb begin
    fix_a  = ({1'b0, cfg_fixed_r} > 5'(FIXED_MAX)) ? 5'(FIXED_MAX) : {1'b0, cfg_fixed_r};
    fix_n  = (fix_a > cfg_total_r) ? cfg_total_r : fix_a;
    free_n = cfg_total_r - fix_n;
    idx5   = {1'b0, in_draw_transmission};
    midx   = idx5 - free_n;
    vec_next = cur_vec_r;
    if (idx5 < free_n) begin
      if (idx5 < 5'(FREE_BITS_MAX)) begin
        vec_next = cur_vec_r ^ (VEC_W'(1) << in_draw_transmission);
      end
    end else if (midx < fix_n) begin
      vec_next = cur_vec_r ^ mask_r[midx[MIDX_W-1:0]];
    end
  end

  // step end position, clipped at the chromosome end
  logic [POS_W:0]   end_sum;
  logic             at_end;
  logic [POS_W-1:0] seg_end;

  assign end_sum = {1'b0, sub_start_r} + {1'b0, POS_W'(in_draw_length)};
  assign at_end  = (end_sum > {1'b0, limit_r});
  assign seg_end = at_end ? limit_r : end_sum[POS_W-1:0];

  // load index checks
  logic tbl_idx_ok, mask_idx_ok;
  assign tbl_idx_ok  = ((16'(in_table_index) >> VEC_W) == 16'd0);
  assign mask_idx_ok = (9'(in_table_index) < 9'(FIXED_MAX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vec_r   <= '0;
      sub_start_r <= '0;
      limit_r     <= '0;
      active_r    <= 1'b0;
      sample_r    <= SAMPLE_W'(1);
      chrom_r     <= '0;
    end else if (accept) begin
      if (is_start) begin
        cur_vec_r   <= VEC_W'(in_start_vector);
        limit_r     <= POS_W'(in_chrom_length);
        sub_start_r <= '0;
        active_r    <= 1'b1;
        if (chrom_r != {CHROM_W{1'b1}}) begin
          chrom_r <= chrom_r + CHROM_W'(1);
        end
      end
      if (is_step) begin
        sub_start_r <= seg_end;
        if (at_end) begin
          active_r <= 1'b0;
        end else begin
          cur_vec_r <= vec_next;
        end
      end
      if (is_finish) begin
        active_r <= 1'b0;
        chrom_r  <= '0;
        if (sample_r != {SAMPLE_W{1'b1}}) begin
          sample_r <= sample_r + SAMPLE_W'(1);
        end
      end
    end
  end

  // flip masks, no reset
  always_ff @(posedge clk) begin
    if (accept && is_load_mask && mask_idx_ok) begin
      mask_r[in_table_index[MIDX_W-1:0]] <= VEC_W'(in_table_value);
    end
  end

  // -------------------------------------------------------------------------
  // state table ram: one write or one read per cycle, registered read
  // -------------------------------------------------------------------------
  logic [1:0]       tbl_mem [TBL_DEPTH];
  logic [1:0]       tbl_rd_r;
  logic             tbl_we, tbl_re;
  logic [VEC_W-1:0] tbl_waddr, tbl_raddr;

  assign tbl_waddr = VEC_W'(in_table_index);
  assign tbl_we    = accept & is_load_state & tbl_idx_ok;
  assign tbl_re    = accept & (is_start | (is_step & ~at_end));
  assign tbl_raddr = is_start ? VEC_W'(in_start_vector) : vec_next;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= in_table_value[1:0];
    end
    if (tbl_re) begin
      tbl_rd_r <= tbl_mem[tbl_raddr];
    end
  end

  // -------------------------------------------------------------------------
  // lookup stage: state compare, run tracking, statistics
  // -------------------------------------------------------------------------
  logic                p1_valid_r;
  logic [2:0]          p1_act_r;
  logic                p1_at_end_r;
  logic [POS_W-1:0]    p1_end_r;
  logic [SAMPLE_W-1:0] p1_sample_r;
  logic [CHROM_W-1:0]  p1_chrom_r;

  logic [1:0]          cur_state_r, cur_state_nxt;
  logic [POS_W-1:0]    run_start_r;
  logic [SUM_W-1:0]    length_sum_r;
  logic [TALLY_W-1:0]  tally_r;

  logic out_valid_r;
  logic p1_step, p1_start, p1_finish, p1_changed, p1_emit_seg, p1_emit, p1_go;
  logic [POS_W-1:0] p1_len;
  logic [ACC_W-1:0] acc_sum;
  logic             stat_hit;

  assign p1_step     = p1_valid_r & (p1_act_r == ibdsg_pkg::ACT_STEP);
  assign p1_start    = p1_valid_r & (p1_act_r == ibdsg_pkg::ACT_START);
  assign p1_finish   = p1_valid_r & (p1_act_r == ibdsg_pkg::ACT_FINISH);
  assign p1_changed  = ~p1_at_end_r & (tbl_rd_r != cur_state_r);
  assign p1_emit_seg = p1_step & (p1_changed | ~cfg_merge_r | p1_at_end_r);
  assign p1_emit     = p1_emit_seg | p1_finish;
  // the stage moves on unless it holds a result and the output is stalled
  assign p1_go       = ~p1_emit | ~out_valid_r | out_tready;
  assign in_tready   = ~p1_valid_r | p1_go;

  assign p1_len   = p1_end_r - run_start_r;
  assign acc_sum  = ACC_W'(length_sum_r) + ACC_W'(p1_len);
  assign stat_hit = (cur_state_r == cfg_stats_r);

  // cached state of the current vector; a table load that hits the current
  // vector is later in order than the lookup finishing now, so it wins
  always_comb begin
    cur_state_nxt = cur_state_r;
    if (p1_go && (p1_start || (p1_step && !p1_at_end_r))) begin
      cur_state_nxt = tbl_rd_r;
    end
    if (tbl_we && (tbl_waddr == cur_vec_r)) begin
      cur_state_nxt = in_table_value[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r   <= 1'b0;
      cur_state_r  <= '0;
      run_start_r  <= '0;
      length_sum_r <= '0;
      tally_r      <= '0;
    end else begin
      cur_state_r <= cur_state_nxt;
      if (accept && (is_start || is_step || is_finish)) begin
        p1_valid_r <= 1'b1;
      end else if (p1_go) begin
        p1_valid_r <= 1'b0;
      end
      if (p1_go) begin
        if (p1_start) begin
          run_start_r <= '0;
        end
        if (p1_emit_seg) begin
          run_start_r <= p1_end_r;
          if (stat_hit) begin
            if (tally_r != {TALLY_W{1'b1}}) begin
              tally_r <= tally_r + TALLY_W'(1);
            end
            length_sum_r <= (acc_sum > ACC_W'({SUM_W{1'b1}})) ?
                            {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
          end
        end
        if (p1_finish) begin
          length_sum_r <= '0;
          tally_r      <= '0;
        end
      end
    end
  end

  // lookup stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_act_r    <= in_action;
      p1_at_end_r <= at_end;
      p1_end_r    <= seg_end;
      p1_sample_r <= sample_r;
      p1_chrom_r  <= chrom_r;
    end
  end

  // -------------------------------------------------------------------------
  // output register
  // -------------------------------------------------------------------------
  logic                out_kind_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic [CHROM_W-1:0]  out_chrom_r;
  logic [31:0]         out_start_r, out_end_r, out_len_r;
  logic [1:0]          out_state_r;
  logic [SUM_W-1:0]    out_total_r;
  logic [TALLY_W-1:0]  out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p1_go && p1_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_go && p1_emit) begin
      out_sample_r <= p1_sample_r;
      out_chrom_r  <= p1_chrom_r;
      if (p1_finish) begin
        out_kind_r  <= ibdsg_pkg::KIND_STATS;
        out_start_r <= '0;
        out_end_r   <= '0;
        out_len_r   <= '0;
        out_state_r <= cfg_stats_r;
        out_total_r <= length_sum_r;
        out_count_r <= tally_r;
      end else begin
        out_kind_r  <= ibdsg_pkg::KIND_SEGMENT;
        out_start_r <= 32'(run_start_r);
        out_end_r   <= 32'(p1_end_r);
        out_len_r   <= 32'(p1_len);
        out_state_r <= cur_state_r;
        out_total_r <= '0;
        out_count_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {6'd0, out_count_r, out_total_r, out_state_r, out_len_r,
                       out_end_r, out_start_r, out_chrom_r, out_sample_r};

endmodule

`default_nettype wire
